FILE: rtl/tod_pkg.sv
// shared types, constants and reciprocal factors for the time of day arithmetic core
// no dependencies
`default_nettype none

package tod_pkg;

  localparam int unsigned DaySec      = 86400;
  localparam int unsigned HourSec     = 3600;
  localparam int unsigned MinSec      = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned MaxHour     = 23;
  localparam int unsigned MaxMinute   = 59;

  localparam int unsigned OpW    = 3;
  localparam int unsigned OffW   = 32;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned TotW   = 17;
  localparam int unsigned ResW   = 18;
  localparam int unsigned QW     = 16;
  localparam int unsigned RemW   = 12;
  localparam int unsigned RelW   = 2;

  // offset / day by reciprocal, estimate low by at most one
  localparam int unsigned RecipDayShift = 48;
  localparam logic [63:0] RecipDay64    = (64'd1 << RecipDayShift) / 64'(DaySec);
  localparam logic [OffW-1:0] RecipDay  = RecipDay64[OffW-1:0];

  // a negative word is raw - 2^32, so add day minus (2^32 mod day)
  localparam logic [63:0]     Wrap64  = (64'd1 << OffW) % 64'(DaySec);
  localparam logic [63:0]     Adj64   = 64'(DaySec) - Wrap64;
  localparam logic [ResW-1:0] WrapAdj = Adj64[ResW-1:0];

  // exact quotients for values below one day and one hour
  localparam int unsigned  HourShift = 27;
  localparam logic [63:0]  RecipHour64 =
    ((64'd1 << HourShift) + 64'(HourSec) - 64'd1) / 64'(HourSec);
  localparam logic [TotW-1:0] RecipHour = RecipHour64[TotW-1:0];

  localparam int unsigned  MinShift = 18;
  localparam logic [63:0]  RecipMin64 =
    ((64'd1 << MinShift) + 64'(MinSec) - 64'd1) / 64'(MinSec);
  localparam logic [RemW:0] RecipMin = RecipMin64[RemW:0];

  typedef enum logic [OpW-1:0] {
    OP_LOAD      = 3'd0,
    OP_ADD       = 3'd1,
    OP_TICK_UP   = 3'd2,
    OP_TICK_DOWN = 3'd3,
    OP_COMPARE   = 3'd4
  } opcode_t;

  typedef enum logic [RelW-1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } relation_t;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } hms_t;

  typedef struct packed {
    opcode_t         op;
    hms_t            given;
    logic [TotW-1:0] given_total;
    logic            load_ok;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    hms_t delta;
  } xfer_t;

endpackage

`default_nettype wire

FILE: rtl/tod_offset_pipe.sv
// pipeline that turns a command into a forward step of hours, minutes and seconds
// depends on tod_pkg
`default_nettype none

module tod_offset_pipe (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [tod_pkg::OpW-1:0]     up_op,
  input  wire logic [tod_pkg::OffW-1:0]    up_offset,
  input  wire tod_pkg::hms_t               up_given,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output tod_pkg::xfer_t                   dn_data
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  tod_pkg::cmd_t s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r, s5_cmd_r, s6_cmd_r;
  logic [tod_pkg::OffW-1:0]  s1_raw_r;
  logic [tod_pkg::QW-1:0]    s1_q_r;
  logic                      s2_neg_r;
  logic [tod_pkg::ResW-1:0]  s2_r0_r;
  logic [tod_pkg::TotW-1:0]  s3_res_r, s4_res_r;
  logic [tod_pkg::HourW-1:0] s4_hq_r, s5_hq_r;
  logic [tod_pkg::RemW-1:0]  s5_rem_r;
  logic [tod_pkg::MinW-1:0]  s5_mq_r;
  tod_pkg::hms_t             s6_delta_r;

  tod_pkg::cmd_t             s1_cmd_nxt;
  logic [tod_pkg::QW-1:0]    s1_q_nxt;
  logic [tod_pkg::ResW-1:0]  s2_r0_nxt;
  logic [tod_pkg::TotW-1:0]  s3_res_nxt;
  logic [tod_pkg::HourW-1:0] s4_hq_nxt;
  logic [tod_pkg::RemW-1:0]  s5_rem_nxt;
  logic [tod_pkg::MinW-1:0]  s5_mq_nxt;
  tod_pkg::hms_t             s6_delta_nxt;

  logic [63:0]                  prod_day;
  logic [tod_pkg::OffW-1:0]     q_day;
  logic [tod_pkg::OffW-1:0]     diff_day;
  logic [tod_pkg::ResW-1:0]     adj;
  logic [2*tod_pkg::TotW-1:0]   prod_hour;
  logic [tod_pkg::TotW-1:0]     h_secs;
  logic [tod_pkg::TotW-1:0]     rem_full;
  logic [2*tod_pkg::RemW:0]     prod_min;
  logic [tod_pkg::RemW-1:0]     m_secs;
  logic [tod_pkg::RemW-1:0]     s_full;

  assign rdy6     = !v6_r || dn_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // stage 1: reciprocal estimate of whole days, given time checks
  always_comb begin
    prod_day   = 64'(up_offset) * 64'(tod_pkg::RecipDay);
    s1_q_nxt   = prod_day[tod_pkg::RecipDayShift +: tod_pkg::QW];
    s1_cmd_nxt.op    = tod_pkg::opcode_t'(up_op);
    s1_cmd_nxt.given = up_given;
    s1_cmd_nxt.given_total =
      tod_pkg::TotW'(up_given.hour)   * tod_pkg::TotW'(tod_pkg::HourSec) +
      tod_pkg::TotW'(up_given.minute) * tod_pkg::TotW'(tod_pkg::MinSec) +
      tod_pkg::TotW'(up_given.second);
    s1_cmd_nxt.load_ok =
      (up_given.hour   <= tod_pkg::HourW'(tod_pkg::MaxHour)) &&
      (up_given.minute <= tod_pkg::MinW'(tod_pkg::MaxMinute)) &&
      (up_given.second <= tod_pkg::SecW'(tod_pkg::MaxMinute));
  end

  // stage 2: remainder, below two days
  always_comb begin
    q_day     = tod_pkg::OffW'(s1_q_r) * tod_pkg::OffW'(tod_pkg::DaySec);
    diff_day  = s1_raw_r - q_day;
    s2_r0_nxt = diff_day[tod_pkg::ResW-1:0];
  end

  // stage 3: sign fix and final reduction, tick steps replace the offset
  always_comb begin
    adj = s2_r0_r + (s2_neg_r ? tod_pkg::WrapAdj : '0);
    if (adj >= tod_pkg::ResW'(2 * tod_pkg::DaySec)) begin
      adj = adj - tod_pkg::ResW'(2 * tod_pkg::DaySec);
    end else if (adj >= tod_pkg::ResW'(tod_pkg::DaySec)) begin
      adj = adj - tod_pkg::ResW'(tod_pkg::DaySec);
    end
    case (s2_cmd_r.op)
      tod_pkg::OP_ADD:       s3_res_nxt = adj[tod_pkg::TotW-1:0];
      tod_pkg::OP_TICK_UP:   s3_res_nxt = tod_pkg::TotW'(1);
      tod_pkg::OP_TICK_DOWN: s3_res_nxt = tod_pkg::TotW'(tod_pkg::DaySec - 1);
      default:               s3_res_nxt = '0;
    endcase
  end

  // stage 4: hours
  always_comb begin
    prod_hour = (2*tod_pkg::TotW)'(s3_res_r) * (2*tod_pkg::TotW)'(tod_pkg::RecipHour);
    s4_hq_nxt = prod_hour[tod_pkg::HourShift +: tod_pkg::HourW];
  end

  // stage 5: seconds within the hour, minutes
  always_comb begin
    h_secs     = tod_pkg::TotW'(s4_hq_r) * tod_pkg::TotW'(tod_pkg::HourSec);
    rem_full   = s4_res_r - h_secs;
    s5_rem_nxt = rem_full[tod_pkg::RemW-1:0];
    prod_min   = (2*tod_pkg::RemW+1)'(s5_rem_nxt) * (2*tod_pkg::RemW+1)'(tod_pkg::RecipMin);
    s5_mq_nxt  = prod_min[tod_pkg::MinShift +: tod_pkg::MinW];
  end

  // stage 6: seconds
  always_comb begin
    m_secs              = tod_pkg::RemW'(s5_mq_r) * tod_pkg::RemW'(tod_pkg::MinSec);
    s_full              = s5_rem_r - m_secs;
    s6_delta_nxt.hour   = s5_hq_r;
    s6_delta_nxt.minute = s5_mq_r;
    s6_delta_nxt.second = s_full[tod_pkg::SecW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cmd_r <= s1_cmd_nxt;
      s1_raw_r <= up_offset;
      s1_q_r   <= s1_q_nxt;
    end
    if (rdy2) begin
      s2_cmd_r <= s1_cmd_r;
      s2_neg_r <= s1_raw_r[tod_pkg::OffW-1];
      s2_r0_r  <= s2_r0_nxt;
    end
    if (rdy3) begin
      s3_cmd_r <= s2_cmd_r;
      s3_res_r <= s3_res_nxt;
    end
    if (rdy4) begin
      s4_cmd_r <= s3_cmd_r;
      s4_res_r <= s3_res_r;
      s4_hq_r  <= s4_hq_nxt;
    end
    if (rdy5) begin
      s5_cmd_r <= s4_cmd_r;
      s5_hq_r  <= s4_hq_r;
      s5_rem_r <= s5_rem_nxt;
      s5_mq_r  <= s5_mq_nxt;
    end
    if (rdy6) begin
      s6_cmd_r   <= s5_cmd_r;
      s6_delta_r <= s6_delta_nxt;
    end
  end

  assign dn_valid      = v6_r;
  assign dn_data.cmd   = s6_cmd_r;
  assign dn_data.delta = s6_delta_r;

endmodule

`default_nettype wire

FILE: rtl/tod_clock_core.sv
// time register with mixed radix step, load and compare, and the result register
// depends on tod_pkg
`default_nettype none

module tod_clock_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire tod_pkg::xfer_t             up_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [tod_pkg::HourW-1:0]       out_hour_now,
  output logic [tod_pkg::MinW-1:0]        out_minute_now,
  output logic [tod_pkg::SecW-1:0]        out_second_now,
  output logic                            out_load_error,
  output logic [tod_pkg::TotW-1:0]        out_difference_seconds,
  output logic [tod_pkg::RelW-1:0]        out_relation
);

  tod_pkg::hms_t             time_r, time_nxt;
  logic                      out_valid_r;
  tod_pkg::hms_t             res_time_r;
  logic                      res_err_r, err_nxt;
  logic [tod_pkg::TotW-1:0]  res_diff_r, diff_nxt;
  tod_pkg::relation_t        res_rel_r, rel_nxt;

  logic                      take;
  logic [tod_pkg::SecW:0]    sum_s;
  logic [tod_pkg::MinW:0]    sum_m;
  logic [tod_pkg::HourW:0]   sum_h;
  logic                      c_s, c_m;
  tod_pkg::hms_t             stepped;
  logic [tod_pkg::TotW-1:0]  now_total;
  logic [tod_pkg::TotW-1:0]  given_total;

  assign up_ready = !out_valid_r || out_ready;
  assign take     = up_valid && up_ready;

  // forward step, each field of the step already in range
  always_comb begin
    sum_s = {1'b0, time_r.second} + {1'b0, up_data.delta.second};
    c_s   = sum_s >= (tod_pkg::SecW+1)'(tod_pkg::MinSec);
    if (c_s) sum_s = sum_s - (tod_pkg::SecW+1)'(tod_pkg::MinSec);
    sum_m = {1'b0, time_r.minute} + {1'b0, up_data.delta.minute} + (tod_pkg::MinW+1)'(c_s);
    c_m   = sum_m >= (tod_pkg::MinW+1)'(tod_pkg::MinSec);
    if (c_m) sum_m = sum_m - (tod_pkg::MinW+1)'(tod_pkg::MinSec);
    sum_h = {1'b0, time_r.hour} + {1'b0, up_data.delta.hour} + (tod_pkg::HourW+1)'(c_m);
    if (sum_h >= (tod_pkg::HourW+1)'(tod_pkg::HoursPerDay)) begin
      sum_h = sum_h - (tod_pkg::HourW+1)'(tod_pkg::HoursPerDay);
    end
    stepped.hour   = sum_h[tod_pkg::HourW-1:0];
    stepped.minute = sum_m[tod_pkg::MinW-1:0];
    stepped.second = sum_s[tod_pkg::SecW-1:0];
  end

  always_comb begin
    now_total   = tod_pkg::TotW'(time_r.hour)   * tod_pkg::TotW'(tod_pkg::HourSec) +
                  tod_pkg::TotW'(time_r.minute) * tod_pkg::TotW'(tod_pkg::MinSec) +
                  tod_pkg::TotW'(time_r.second);
    given_total = up_data.cmd.given_total;
    time_nxt    = time_r;
    err_nxt     = 1'b0;
    diff_nxt    = '0;
    rel_nxt     = tod_pkg::REL_LESS;
    case (up_data.cmd.op)
      tod_pkg::OP_LOAD: begin
        if (up_data.cmd.load_ok) time_nxt = up_data.cmd.given;
        else err_nxt = 1'b1;
      end
      tod_pkg::OP_ADD, tod_pkg::OP_TICK_UP, tod_pkg::OP_TICK_DOWN: begin
        time_nxt = stepped;
      end
      tod_pkg::OP_COMPARE: begin
        if (now_total < given_total) begin
          diff_nxt = given_total - now_total;
          rel_nxt  = tod_pkg::REL_LESS;
        end else if (now_total == given_total) begin
          rel_nxt  = tod_pkg::REL_EQUAL;
        end else begin
          diff_nxt = now_total - given_total;
          rel_nxt  = tod_pkg::REL_GREATER;
        end
      end
      default: begin
        time_nxt = time_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) time_r <= time_nxt;
      if (up_ready) out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_time_r <= time_nxt;
      res_err_r  <= err_nxt;
      res_diff_r <= diff_nxt;
      res_rel_r  <= rel_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_hour_now           = res_time_r.hour;
  assign out_minute_now         = res_time_r.minute;
  assign out_second_now         = res_time_r.second;
  assign out_load_error         = res_err_r;
  assign out_difference_seconds = res_diff_r;
  assign out_relation           = res_rel_r;

endmodule

`default_nettype wire

FILE: rtl/time_of_day_arithmetic_core.sv
// top level of the time of day arithmetic core: input register, offset pipeline, time register
// depends on tod_pkg, tod_offset_pipe, tod_clock_core
//
//   port group  dir  handshake          word
//   in_*        in   in_valid/in_ready  opcode, offset_seconds, given_hour/minute/second
//   out_*       out  out_valid/out_ready hour/minute/second_now, load_error,
//                                        difference_seconds, relation
//
// one word per cycle sustained while out_ready holds high; a taken word passes in order
// through the input register, six offset pipeline stages and the result register
// the time register sits in the last stage and changes as a word enters the result register
// rst_n clears the time to 00:00:00 and empties every stage
// each stage holds while the one after it is full and stalled, so bubbles are squeezed out
`default_nettype none

module time_of_day_arithmetic_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tod_pkg::OpW-1:0]        in_opcode,
  input  wire logic signed [tod_pkg::OffW-1:0] in_offset_seconds,
  input  wire logic [tod_pkg::HourW-1:0]      in_given_hour,
  input  wire logic [tod_pkg::MinW-1:0]       in_given_minute,
  input  wire logic [tod_pkg::SecW-1:0]       in_given_second,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tod_pkg::HourW-1:0]           out_hour_now,
  output logic [tod_pkg::MinW-1:0]            out_minute_now,
  output logic [tod_pkg::SecW-1:0]            out_second_now,
  output logic                                out_load_error,
  output logic [tod_pkg::TotW-1:0]            out_difference_seconds,
  output logic [tod_pkg::RelW-1:0]            out_relation
);

  logic                     v0_r;
  logic [tod_pkg::OpW-1:0]  op_r;
  logic [tod_pkg::OffW-1:0] off_r;
  tod_pkg::hms_t            given_r;
  logic                     pipe_ready;
  logic                     core_valid;
  logic                     core_ready;
  tod_pkg::xfer_t           core_data;

  assign in_ready = !v0_r || pipe_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      op_r           <= in_opcode;
      off_r          <= in_offset_seconds;
      given_r.hour   <= in_given_hour;
      given_r.minute <= in_given_minute;
      given_r.second <= in_given_second;
    end
  end

  tod_offset_pipe u_offset_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v0_r),
    .up_ready  (pipe_ready),
    .up_op     (op_r),
    .up_offset (off_r),
    .up_given  (given_r),
    .dn_valid  (core_valid),
    .dn_ready  (core_ready),
    .dn_data   (core_data)
  );

  tod_clock_core u_clock_core (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .up_valid               (core_valid),
    .up_ready               (core_ready),
    .up_data                (core_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_hour_now           (out_hour_now),
    .out_minute_now         (out_minute_now),
    .out_second_now         (out_second_now),
    .out_load_error         (out_load_error),
    .out_difference_seconds (out_difference_seconds),
    .out_relation           (out_relation)
  );

endmodule

`default_nettype wire

FILE: verif/tod_checker.sv
// result checker for the time of day arithmetic core: tracks its own copy of the time,
// predicts every reading from the accepted command words and compares field by field
// depends on tod_pkg
module tod_checker
  import tod_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [OpW-1:0]         in_opcode,
  input  logic signed [OffW-1:0] in_offset_seconds,
  input  logic [HourW-1:0]       in_given_hour,
  input  logic [MinW-1:0]        in_given_minute,
  input  logic [SecW-1:0]        in_given_second,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [HourW-1:0]       out_hour_now,
  input  logic [MinW-1:0]        out_minute_now,
  input  logic [SecW-1:0]        out_second_now,
  input  logic                   out_load_error,
  input  logic [TotW-1:0]        out_difference_seconds,
  input  logic [RelW-1:0]        out_relation,
  output int unsigned            mismatches,
  output int unsigned            readings_due,
  output int unsigned            words_taken,
  output int unsigned            rejected_loads,
  output int unsigned            compares_done
);

  typedef struct {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic             load_error;
    logic [TotW-1:0]  difference;
    logic [RelW-1:0]  relation;
  } reading_t;

  reading_t         due_readings[$];
  logic [HourW-1:0] clock_hour;
  logic [MinW-1:0]  clock_minute;
  logic [SecW-1:0]  clock_second;

  initial begin
    mismatches     = 0;
    readings_due   = 0;
    words_taken    = 0;
    rejected_loads = 0;
    compares_done  = 0;
    clock_hour     = '0;
    clock_minute   = '0;
    clock_second   = '0;
  end

  function automatic void set_clock(longint total);
    longint t;
    t            = total % longint'(DaySec);
    clock_hour   = HourW'(t / longint'(HourSec));
    t            = t % longint'(HourSec);
    clock_minute = MinW'(t / longint'(MinSec));
    clock_second = SecW'(t % longint'(MinSec));
  endfunction

  // advances the kept time by one command word and returns the reading it gives
  function automatic reading_t next_time_reading(logic [OpW-1:0] op,
                                                 logic signed [OffW-1:0] offset,
                                                 logic [HourW-1:0] gh,
                                                 logic [MinW-1:0] gm,
                                                 logic [SecW-1:0] gs);
    reading_t r;
    longint   now_s;
    longint   given_s;
    longint   shift;
    r.load_error = 1'b0;
    r.difference = '0;
    r.relation   = REL_LESS;
    now_s   = longint'(clock_hour) * longint'(HourSec)
            + longint'(clock_minute) * longint'(MinSec) + longint'(clock_second);
    given_s = longint'(gh) * longint'(HourSec) + longint'(gm) * longint'(MinSec)
            + longint'(gs);
    case (op)
      OP_LOAD: begin
        if (gh > MaxHour || gm > MaxMinute || gs > MaxMinute) begin
          r.load_error = 1'b1;
          rejected_loads++;
        end else begin
          clock_hour   = gh;
          clock_minute = gm;
          clock_second = gs;
        end
      end
      OP_ADD: begin
        shift = longint'(offset) % longint'(DaySec);
        if (shift < 0) shift += longint'(DaySec);
        set_clock(now_s + shift);
      end
      OP_TICK_UP:   set_clock(now_s + 1);
      OP_TICK_DOWN: set_clock(now_s + longint'(DaySec) - 1);
      OP_COMPARE: begin
        compares_done++;
        if (now_s < given_s) begin
          r.difference = TotW'(given_s - now_s);
          r.relation   = REL_LESS;
        end else if (now_s == given_s) begin
          r.relation   = REL_EQUAL;
        end else begin
          r.difference = TotW'(now_s - given_s);
          r.relation   = REL_GREATER;
        end
      end
      default: ;
    endcase
    r.hour   = clock_hour;
    r.minute = clock_minute;
    r.second = clock_second;
    return r;
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      clock_hour   = '0;
      clock_minute = '0;
      clock_second = '0;
      due_readings.delete();
    end else begin
      if (in_valid && in_ready) begin
        due_readings.push_back(next_time_reading(in_opcode, in_offset_seconds,
                                                 in_given_hour, in_given_minute,
                                                 in_given_second));
        words_taken++;
      end
      if (out_valid && out_ready) begin
        if (due_readings.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none, got %0d:%0d:%0d", $time,
                   out_hour_now, out_minute_now, out_second_now);
        end else begin
          want = due_readings.pop_front();
          check_field("hour_now", want.hour, out_hour_now);
          check_field("minute_now", want.minute, out_minute_now);
          check_field("second_now", want.second, out_second_now);
          check_field("load_error", want.load_error, out_load_error);
          check_field("difference_seconds", want.difference, out_difference_seconds);
          check_field("relation", want.relation, out_relation);
        end
      end
    end
    readings_due = due_readings.size();
  end

endmodule

FILE: verif/tb.sv
// testbench top for the time of day arithmetic core: clock, reset, directed and random
// command words, random stalls on both sides, verdict
// depends on tod_pkg, tod_checker and the core rtl
module tb;
  import tod_pkg::*;

  localparam logic [OpW-1:0] OpSpareFirst = 3'd5;
  localparam logic [OpW-1:0] OpSpareLast  = 3'd7;
  localparam int             RandomWords  = 1230;
  localparam int             LongHold     = 120;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [OpW-1:0]         in_opcode;
  logic signed [OffW-1:0] in_offset_seconds;
  logic [HourW-1:0]       in_given_hour;
  logic [MinW-1:0]        in_given_minute;
  logic [SecW-1:0]        in_given_second;
  logic                   out_valid;
  logic                   out_ready;
  logic [HourW-1:0]       out_hour_now;
  logic [MinW-1:0]        out_minute_now;
  logic [SecW-1:0]        out_second_now;
  logic                   out_load_error;
  logic [TotW-1:0]        out_difference_seconds;
  logic [RelW-1:0]        out_relation;
  logic                   in_took = 1'b0;
  int unsigned            mismatches;
  int unsigned            readings_due;
  int unsigned            words_taken;
  int unsigned            rejected_loads;
  int unsigned            compares_done;
  int                     burst_left = 0;
  int                     cycles_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  time_of_day_arithmetic_core i_dut (.*);

  tod_checker i_checker (.*);

  always @(posedge clk) begin
    in_took <= in_valid && in_ready && rst_n;
    cycles_run <= cycles_run + 1;
  end

  task automatic offer_word(input logic [OpW-1:0] op, input logic signed [OffW-1:0] offset,
                            input logic [HourW-1:0] gh, input logic [MinW-1:0] gm,
                            input logic [SecW-1:0] gs);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_offset_seconds <= offset;
    in_given_hour     <= gh;
    in_given_minute   <= gm;
    in_given_second   <= gs;
    do @(negedge clk); while (!in_took);
  endtask

  // receiver: stall patterns of varying density, one long hold-off mid run
  initial begin : receiver
    int  style;
    int  span;
    bit  held;
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      if (!held && cycles_run > 300) begin
        held = 1'b1;
        repeat (LongHold) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int                     pick;
    logic signed [OffW-1:0] offset;
    logic [HourW-1:0]       h;
    logic [MinW-1:0]        m;
    logic [SecW-1:0]        s;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_opcode         = OP_LOAD;
    in_offset_seconds = '0;
    in_given_hour     = '0;
    in_given_minute   = '0;
    in_given_second   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // midnight wrap both ways, range checks on load
    offer_word(OP_TICK_DOWN, 0, 0, 0, 0);
    offer_word(OP_TICK_UP, 0, 0, 0, 0);
    offer_word(OP_LOAD, 0, 23, 59, 59);
    offer_word(OP_TICK_UP, 0, 0, 0, 0);
    offer_word(OP_TICK_DOWN, 0, 0, 0, 0);
    offer_word(OP_LOAD, 0, 24, 0, 0);
    offer_word(OP_LOAD, 0, 0, 60, 0);
    offer_word(OP_LOAD, 0, 0, 0, 60);
    offer_word(OP_LOAD, 0, 31, 63, 63);
    // compare against equal, earlier, later and out-of-range times
    offer_word(OP_LOAD, 0, 12, 34, 56);
    offer_word(OP_COMPARE, 0, 12, 34, 56);
    offer_word(OP_COMPARE, 0, 0, 0, 0);
    offer_word(OP_COMPARE, 0, 23, 59, 59);
    offer_word(OP_COMPARE, 0, 31, 63, 63);
    // offset extremes and whole days, then the spare opcodes
    offer_word(OP_ADD, 32'sh7fffffff, 0, 0, 0);
    offer_word(OP_ADD, 32'sh80000000, 0, 0, 0);
    offer_word(OP_ADD, -1, 0, 0, 0);
    offer_word(OP_ADD, 0, 0, 0, 0);
    offer_word(OP_ADD, 86400, 0, 0, 0);
    offer_word(OP_ADD, -86399, 0, 0, 0);
    for (int op = OpSpareFirst; op <= OpSpareLast; op++)
      offer_word(OpW'(op), $urandom, $urandom_range(0, 31), $urandom_range(0, 63),
                 $urandom_range(0, 63));

    for (int n = 0; n < RandomWords; n++) begin
      pick = $urandom_range(0, 99);
      h    = $urandom_range(0, 23);
      m    = $urandom_range(0, 59);
      s    = $urandom_range(0, 59);
      case ($urandom_range(0, 3))
        0: offset = int'($urandom_range(0, 200)) - 100;
        1: offset = $urandom;
        2: offset = (int'($urandom_range(0, 40000)) - 20000) * 86400
                    + int'($urandom_range(0, 4)) - 2;
        default: begin
          case ($urandom_range(0, 3))
            0: offset = 32'sh7fffffff;
            1: offset = 32'sh80000000;
            2: offset = -1;
            default: offset = 0;
          endcase
        end
      endcase
      if (pick < 8) begin
        offer_word(OP_LOAD, offset, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63));
      end else if (pick < 24) begin
        offer_word(OP_LOAD, offset, h, m, s);
      end else if (pick < 32) begin
        if ($urandom_range(0, 1)) begin
          offer_word(OP_LOAD, offset, 0, 0, 0);
          offer_word(OP_TICK_DOWN, offset, h, m, s);
        end else begin
          offer_word(OP_LOAD, offset, h, m, s);
          offer_word(OP_COMPARE, offset, h, m, s);
        end
        n++;
      end else if (pick < 50) begin
        offer_word(OP_ADD, offset, h, m, s);
      end else if (pick < 64) begin
        offer_word(OP_TICK_UP, offset, h, m, s);
      end else if (pick < 78) begin
        offer_word(OP_TICK_DOWN, offset, h, m, s);
      end else if (pick < 95) begin
        if ($urandom_range(0, 4) == 0)
          offer_word(OP_COMPARE, offset, $urandom_range(0, 31), $urandom_range(0, 63),
                     $urandom_range(0, 63));
        else
          offer_word(OP_COMPARE, offset, h, m, s);
      end else begin
        offer_word($urandom_range(OpSpareFirst, OpSpareLast), offset, h, m, s);
      end
    end

    in_valid <= 1'b0;
    while (readings_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d command words checked, %0d rejected loads, %0d compares, %0d cycles",
             words_taken, rejected_loads, compares_done, cycles_run);
    if (mismatches == 0 && readings_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("timed out with %0d readings outstanding", readings_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
